// ----- src/gbc_pkg.sv -----
// gbc_pkg: shared types, constants and round function of the GOST block cipher.
// Used by gbc_key_regs, gbc_stage and gost_block_cipher_ecb; depends on nothing.
package gbc_pkg;

   localparam int ROUNDS      = 32;
   localparam int KEY_WORDS   = 8;
   localparam int ROT_LEFT    = 11;
   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] KEY_PAIR_0 = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] KEY_PAIR_1 = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] KEY_PAIR_2 = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] KEY_PAIR_3 = 8'd3;

   typedef logic [KEY_WORDS-1:0][31:0] key_words_type;

   typedef struct packed {
      logic        valid;
      logic        dec;
      logic [31:0] left;
      logic [31:0] right;
   } stage_type;

   localparam logic [3:0] SBOX [8][16] = '{
      '{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
        4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
      '{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
        4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
      '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
        4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
      '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
        4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
      '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
        4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
      '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
        4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
      '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
        4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
      '{4'h1, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
        4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'hC}
   };

   // add key, substitute nibbles, rotate, mix into the other half
   function automatic logic [31:0] round_f(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] k);
      logic [31:0] s;
      logic [31:0] t;
      s = a + k;
      t = '0;
      for (int i = 0; i < 4; i++) begin
         t[8*i+4 +: 4] = SBOX[2*i][s[8*i+4 +: 4]];
         t[8*i   +: 4] = SBOX[2*i+1][s[8*i +: 4]];
      end
      return {t[31-ROT_LEFT:0], t[31:32-ROT_LEFT]} ^ b;
   endfunction

endpackage

// ----- src/gbc_key_regs.sv -----
// gbc_key_regs: the four 64-bit key pair registers and their write port.
// Depends on gbc_pkg.
module gbc_key_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [gbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                        csr_wdata,
   output gbc_pkg::key_words_type             key_words
);

   logic [3:0][63:0] key_pair_ff;
   logic [3:0][63:0] key_pair_in;

   always_comb begin
      key_pair_in = key_pair_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gbc_pkg::KEY_PAIR_0: key_pair_in[0] = csr_wdata;
            gbc_pkg::KEY_PAIR_1: key_pair_in[1] = csr_wdata;
            gbc_pkg::KEY_PAIR_2: key_pair_in[2] = csr_wdata;
            gbc_pkg::KEY_PAIR_3: key_pair_in[3] = csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pair_ff <= '0;
      end else begin
         key_pair_ff <= key_pair_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         key_words[2*i]   = key_pair_ff[i][31:0];
         key_words[2*i+1] = key_pair_ff[i][63:32];
      end
   end

endmodule

// ----- src/gbc_stage.sv -----
// gbc_stage: one registered Feistel round with its valid bit and stall chain.
// Depends on gbc_pkg.
module gbc_stage (
   input  logic               clock,
   input  logic               reset,
   input  gbc_pkg::stage_type stage_i,
   input  logic [31:0]        key_enc,
   input  logic [31:0]        key_dec,
   input  logic               swap,
   input  logic               next_ready,
   output logic               ready,
   output gbc_pkg::stage_type stage_o
);

   gbc_pkg::stage_type stage_ff;
   gbc_pkg::stage_type stage_in;
   logic [31:0]        key;
   logic [31:0]        f;

   assign key = stage_i.dec ? key_dec : key_enc;
   assign f   = gbc_pkg::round_f(stage_i.left, stage_i.right, key);

   always_comb begin
      stage_in.valid = stage_i.valid;
      stage_in.dec   = stage_i.dec;
      stage_in.left  = swap ? f : stage_i.left;
      stage_in.right = swap ? stage_i.left : f;
   end

   // advance when empty or when the next stage takes our item
   assign ready = !stage_ff.valid || next_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (ready) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

// ----- src/gost_block_cipher_ecb.sv -----
// gost_block_cipher_ecb: 32-round GOST 28147-89 ECB engine, one round per stage.
// Depends on gbc_pkg, gbc_key_regs and gbc_stage.
//
// Accepts one 64-bit request per clock unless stalled and returns it encrypted
// (req_type 0) or decrypted (req_type 1), in order. Each of the 32 pipeline
// stages holds one round (key add, S-boxes, rotate, XOR); the last stage is the
// output register. A stalled output holds only the stages behind it that are
// full, so empty slots keep filling while a result waits. The key lives in four
// 64-bit registers written through the csr_ port (index 0..3, others ignored),
// which is always ready; change the key only when no request is in flight.
module gost_block_cipher_ecb (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [63:0]                      req_block_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [63:0]                      rsp_block_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gbc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [63:0]                      csr_wdata
);

   gbc_pkg::key_words_type key_words;
   gbc_pkg::stage_type     pipe [gbc_pkg::ROUNDS+1];
   logic [gbc_pkg::ROUNDS:0] rdy;

   assign csr_ready = 1'b1;

   gbc_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key_words (key_words)
   );

   assign pipe[0] = {req_valid, req_type, req_block_in};

   assign rdy[gbc_pkg::ROUNDS] = !rsp_stall;
   assign req_stall            = !rdy[0];

   for (genvar s = 0; s < gbc_pkg::ROUNDS; s++) begin : g_round
      localparam int KE = (s < 24) ? (s % 8) : (7 - (s % 8));
      localparam int KD = (s < 8) ? s : (7 - (s % 8));

      gbc_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .stage_i    (pipe[s]),
         .key_enc    (key_words[KE]),
         .key_dec    (key_words[KD]),
         .swap       ((s == gbc_pkg::ROUNDS - 1) ? 1'b0 : 1'b1),
         .next_ready (rdy[s+1]),
         .ready      (rdy[s]),
         .stage_o    (pipe[s+1])
      );
   end

   assign rsp_valid     = pipe[gbc_pkg::ROUNDS].valid;
   assign rsp_block_out = {pipe[gbc_pkg::ROUNDS].left, pipe[gbc_pkg::ROUNDS].right};

endmodule
